// ===== hdl/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      FN_APPEND    = 2'd0,
      FN_BACKPATCH = 2'd1,
      FN_MERGE     = 2'd2,
      FN_UNUSED    = 2'd3
   } func_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_DEPTH = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_BP_CHECK,
      S_BP_READ,
      S_MG_CHK2,
      S_MG_CHKF,
      S_MG_READ,
      S_DONE
   } state_type;

   // Compare results from the shared walk unit.
   typedef struct packed {
      logic idx_zero;
      logic out_of_range;
      logic depth_hit;
      logic depth_next_hit;
      logic full;
   } walk_flags_type;

endpackage

`default_nettype wire

// ===== hdl/bpc_mem.sv =====
`default_nettype none

module bpc_mem #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]                     wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic      [7:0]                     rd_data
);

   logic [7:0] mem_ff [TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bpc_walk.sv =====
`default_nettype none

module bpc_walk
   import bpc_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic [7:0]                       idx,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] count,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] steps,
   output logic      [$clog2(TABLE_DEPTH+1)-1:0] steps_inc,
   output walk_flags_type                        flags
);

   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam int CmpW = (CntW > 8) ? CntW : 8;

   logic [CmpW-1:0] idx_ext;
   logic [CmpW-1:0] count_ext;

   assign idx_ext   = CmpW'(idx);
   assign count_ext = CmpW'(count);
   assign steps_inc = steps + CntW'(1);

   // Two index compares, two step compares and one count compare, shared by every walk state.
   always_comb begin
      flags.idx_zero       = (idx == 8'd0);
      flags.out_of_range   = (idx_ext >= count_ext);
      flags.depth_hit      = (steps >= CntW'(TABLE_DEPTH));
      flags.depth_next_hit = (steps_inc >= CntW'(TABLE_DEPTH));
      flags.full           = (count >= CntW'(TABLE_DEPTH));
   end

endmodule

`default_nettype wire

// ===== hdl/backpatch_chain_table.sv =====
// Backpatch chain table: a table of 8-bit jump targets, one per emitted
// quadruple, with append, backpatch and merge operations on linked chains.
// Entry 0 is a dummy, so indexes start at 1 and index 0 ends a chain.
//
// The request channel (req_*) takes one item when req_valid is high and
// req_stall is low; the block holds req_stall high from the cycle after an
// accepted item until its result has been moved into the response register.
// The response channel (rsp_*) presents one result item per request and
// holds it while rsp_stall is high; the block keeps working meanwhile and
// waits only if a second result would overwrite one still held.
//
// Timing is set by the chain walk over the table memory, which has one
// read and one write port and whose read data is registered. An append
// writes one entry, an unused code goes straight to its result, a
// backpatch reads then rewrites each link, and a merge makes one
// dependent read per link of its second chain. The next item is not
// taken before its predecessor's result is registered.
// Synchronous reset empties the response register, returns the sequencer
// to idle and sets the entry count to one. Table contents are not cleared:
// entry 0 is never read, and no entry at or beyond the count is read.
`default_nettype none

module backpatch_chain_table
   import bpc_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_first_chain,
   input  wire logic [7:0] req_second_chain,
   input  wire logic [7:0] req_value,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_head_or_index,
   output logic      [1:0] rsp_status
);

   localparam int CntW  = $clog2(TABLE_DEPTH + 1);
   localparam int AddrW = $clog2(TABLE_DEPTH);

   // Sequencer and item registers.
   state_type       state_ff, state_in;
   logic [7:0]      first_ff, first_in;
   logic [7:0]      second_ff, second_in;
   logic [7:0]      value_ff, value_in;
   logic [7:0]      q_ff, q_in;          // current chain position
   logic [CntW-1:0] steps_ff, steps_in;  // links walked so far
   logic [CntW-1:0] count_ff, count_in;  // entries in use

   // Finished result, waiting for the response register.
   logic [7:0]      res_head_ff, res_head_in;
   status_type      res_status_ff, res_status_in;

   // Response register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_head_ff, rsp_head_in;
   status_type      rsp_status_ff, rsp_status_in;

   // Memory port and walk unit connections.
   logic             mem_wr_en;
   logic [AddrW-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [AddrW-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;

   logic [7:0]       walk_idx;
   logic [CntW-1:0]  steps_inc;
   walk_flags_type   flags;
   logic             rsp_free;

   bpc_mem #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   bpc_walk #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_walk (
      .idx      (walk_idx),
      .count    (count_ff),
      .steps    (steps_ff),
      .steps_inc(steps_inc),
      .flags    (flags)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // The walk unit's index operand: the link just read while a merge walks,
   // the first chain while the merge checks it, otherwise the chain position.
   always_comb begin
      case (state_ff)
         S_MG_CHKF: walk_idx = first_ff;
         S_MG_READ: walk_idx = mem_rd_data;
         default:   walk_idx = q_ff;
      endcase
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FN_APPEND:    state_in = S_APPEND;
                  FN_BACKPATCH: state_in = S_BP_CHECK;
                  FN_MERGE:     state_in = S_MG_CHK2;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_APPEND: state_in = S_DONE;
         S_BP_CHECK: begin
            if (flags.idx_zero || flags.out_of_range || flags.depth_hit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_BP_READ;
            end
         end
         S_BP_READ: state_in = S_BP_CHECK;
         S_MG_CHK2: begin
            if (flags.idx_zero || flags.out_of_range) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MG_CHKF;
            end
         end
         S_MG_CHKF: begin
            if (flags.out_of_range) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MG_READ;
            end
         end
         S_MG_READ: begin
            if (flags.idx_zero || flags.out_of_range || flags.depth_next_hit) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory port and result control.
   always_comb begin
      first_in      = first_ff;
      second_in     = second_ff;
      value_in      = value_ff;
      q_in          = q_ff;
      steps_in      = steps_ff;
      count_in      = count_ff;
      res_head_in   = res_head_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_head_in   = rsp_head_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = AddrW'(q_ff);
      mem_wr_data   = value_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = AddrW'(q_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               first_in      = req_first_chain;
               second_in     = req_second_chain;
               value_in      = req_value;
               q_in          = (req_func == FN_BACKPATCH) ? req_first_chain
                                                          : req_second_chain;
               steps_in      = '0;
               res_head_in   = 8'd0;
               res_status_in = ST_OK;
            end
         end
         S_APPEND: begin
            if (flags.full) begin
               res_status_in = ST_FULL;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AddrW'(count_ff);
               res_head_in = 8'(count_ff);
               count_in    = count_ff + CntW'(1);
            end
         end
         S_BP_CHECK: begin
            // A zero position ends the chain with the default ok result.
            if (!flags.idx_zero) begin
               if (flags.out_of_range) begin
                  res_status_in = ST_RANGE;
               end else if (flags.depth_hit) begin
                  res_status_in = ST_DEPTH;
               end else begin
                  mem_rd_en = 1'b1;
               end
            end
         end
         S_BP_READ: begin
            // Follow the old link, then overwrite it with the patch value.
            mem_wr_en = 1'b1;
            q_in      = mem_rd_data;
            steps_in  = steps_inc;
         end
         S_MG_CHK2: begin
            if (flags.idx_zero) begin
               res_head_in = first_ff;
            end else if (flags.out_of_range) begin
               res_status_in = ST_RANGE;
            end
         end
         S_MG_CHKF: begin
            if (flags.out_of_range) begin
               res_status_in = ST_RANGE;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         S_MG_READ: begin
            if (flags.idx_zero) begin
               // Tail found: link it to the first chain.
               mem_wr_en   = 1'b1;
               mem_wr_data = first_ff;
               res_head_in = second_ff;
            end else if (flags.out_of_range) begin
               res_status_in = ST_RANGE;
            end else if (flags.depth_next_hit) begin
               res_status_in = ST_DEPTH;
            end else begin
               q_in        = mem_rd_data;
               steps_in    = steps_inc;
               mem_rd_en   = 1'b1;
               mem_rd_addr = AddrW'(mem_rd_data);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_head_in   = res_head_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CntW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      second_ff     <= second_in;
      value_ff      <= value_in;
      q_ff          <= q_in;
      steps_ff      <= steps_in;
      res_head_ff   <= res_head_in;
      res_status_ff <= res_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_or_index = rsp_head_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hdl/bpc_checker.sv =====
`default_nettype none

module bpc_checker
   import bpc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_head_or_index,
   input wire logic [1:0] rsp_status
);

   // A held result keeps its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_head_or_index)
                                 && $stable(rsp_status))
      else $error("response changed while stalled");

   // The block is busy right after it takes an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken in back-to-back cycles");

   // A result never appears in the cycle right after an item is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response appeared too early");

   // Error results carry a zero head.
   a_err_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_head_or_index == 8'd0)
      else $error("error response with nonzero head");

endmodule

bind backpatch_chain_table bpc_checker u_bpc_checker (.*);

`default_nettype wire
